/* hdl/radial_spotlight_dimmer_macros.svh */
// Assertion macros for the radial spotlight dimmer.
// RSD_ASSERT_NOW checks a condition at every clock edge outside reset.
// RSD_ASSERT_NEXT checks that a condition holds in the cycle after a trigger.
`ifndef RADIAL_SPOTLIGHT_DIMMER_MACROS_SVH
`define RADIAL_SPOTLIGHT_DIMMER_MACROS_SVH
`ifndef SYNTHESIS
`define RSD_ASSERT_NOW(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define RSD_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");
`else
`define RSD_ASSERT_NOW(lbl, clk, rst, cond)
`define RSD_ASSERT_NEXT(lbl, clk, rst, trig, cond)
`endif
`endif

/* hdl/rsd_pkg.sv */
package rsd_pkg;

   localparam int CENTER_BITS = 14;
   localparam int CHAN_BITS   = 8;
   localparam int DELTA_BITS  = 15;
   localparam int MAG_BITS    = 14;
   localparam int SQ_BITS     = 2 * MAG_BITS;
   localparam int SUM_BITS    = SQ_BITS + 1;
   localparam int ROOT_BITS   = 8;
   localparam int RAD_BITS    = 2 * ROOT_BITS;
   localparam int REM_BITS    = ROOT_BITS + 2;
   localparam int PROD_BITS   = 2 * CHAN_BITS;
   localparam int QUOT_BITS   = PROD_BITS - 3;
   localparam int RECIP_SHIFT = 17;
   localparam int RECIP_BITS  = 2 * QUOT_BITS;
   localparam int FRONT_STAGES = 3;
   localparam int CELL_COUNT   = ROOT_BITS;
   localparam int SCALE_STAGES = 2;
   localparam int STAGE_COUNT  = FRONT_STAGES + CELL_COUNT + SCALE_STAGES;

   localparam logic [ROOT_BITS-1:0] SPOT_RADIUS = ROOT_BITS'(200);
   localparam logic [SUM_BITS-1:0]  FAR_LIMIT   = SUM_BITS'(200 * 200);
   // floor(q / 25) == (q * 5243) >> 17 for every q below 8192
   localparam logic [QUOT_BITS-1:0] RECIP_25    = QUOT_BITS'(5243);

   typedef enum logic [0:0] {
      CSR_CENTER_X = 1'b0,
      CSR_CENTER_Y = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic                 valid;
      logic                 far;
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
      logic [RAD_BITS-1:0]  rad;
      rgb_type              rgb;
   } root_stage_type;

endpackage

/* hdl/rsd_front.sv */
module rsd_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rsd_pkg::FRONT_STAGES-1:0]    advance,
   input  logic                                in_valid,
   input  logic [COORD_BITS-1:0]               pos_x,
   input  logic [COORD_BITS-1:0]               pos_y,
   input  rsd_pkg::rgb_type                    rgb,
   input  logic [rsd_pkg::CENTER_BITS-1:0]     center_x,
   input  logic [rsd_pkg::CENTER_BITS-1:0]     center_y,
   output logic [rsd_pkg::FRONT_STAGES-1:0]    busy,
   output rsd_pkg::root_stage_type             out_stage
);

   localparam int DB = rsd_pkg::DELTA_BITS;
   localparam int MB = rsd_pkg::MAG_BITS;
   localparam int SB = rsd_pkg::SQ_BITS;
   localparam int UB = rsd_pkg::SUM_BITS;

   logic [DB-1:0] diff_x, diff_y;
   logic [MB-1:0] mag_x_in, mag_y_in;
   logic [UB-1:0] sum_in;

   logic             a_valid_ff, b_valid_ff, c_valid_ff;
   logic [MB-1:0]    a_mx_ff, a_my_ff;
   rsd_pkg::rgb_type a_rgb_ff, b_rgb_ff, c_rgb_ff;
   logic [SB-1:0]    b_sqx_ff, b_sqy_ff;
   logic [UB-1:0]    c_sum_ff;

   always_comb begin
      diff_x = DB'(pos_x) - DB'(signed'(center_x));
      diff_y = DB'(pos_y) - DB'(signed'(center_y));
      mag_x_in = diff_x[DB-1] ? MB'(~diff_x + DB'(1)) : diff_x[MB-1:0];
      mag_y_in = diff_y[DB-1] ? MB'(~diff_y + DB'(1)) : diff_y[MB-1:0];
      sum_in = UB'(b_sqx_ff) + UB'(b_sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (advance[0]) a_valid_ff <= in_valid;
         if (advance[1]) b_valid_ff <= a_valid_ff;
         if (advance[2]) c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         a_mx_ff  <= mag_x_in;
         a_my_ff  <= mag_y_in;
         a_rgb_ff <= rgb;
      end
      if (advance[1]) begin
         b_sqx_ff <= SB'(a_mx_ff) * SB'(a_mx_ff);
         b_sqy_ff <= SB'(a_my_ff) * SB'(a_my_ff);
         b_rgb_ff <= a_rgb_ff;
      end
      if (advance[2]) begin
         c_sum_ff <= sum_in;
         c_rgb_ff <= b_rgb_ff;
      end
   end

   assign busy = {c_valid_ff, b_valid_ff, a_valid_ff};

   always_comb begin
      out_stage       = '0;
      out_stage.valid = c_valid_ff;
      out_stage.far   = c_sum_ff >= rsd_pkg::FAR_LIMIT;
      out_stage.rad   = c_sum_ff[rsd_pkg::RAD_BITS-1:0];
      out_stage.rgb   = c_rgb_ff;
   end

endmodule

/* hdl/rsd_root_cell.sv */
`include "radial_spotlight_dimmer_macros.svh"

module rsd_root_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  rsd_pkg::root_stage_type in_stage,
   output rsd_pkg::root_stage_type out_stage
);

   localparam int RB = rsd_pkg::ROOT_BITS;
   localparam int EB = rsd_pkg::REM_BITS;
   localparam int WB = EB + 2;
   localparam int AB = rsd_pkg::RAD_BITS;

   logic [WB-1:0] cur, trial, diff;
   logic          fits;
   rsd_pkg::root_stage_type stage_in, stage_ff;

   always_comb begin
      cur   = {in_stage.rem, in_stage.rad[AB-1 -: 2]};
      trial = {2'b00, in_stage.root, 2'b01};
      fits  = cur >= trial;
      diff  = cur - trial;
      stage_in      = in_stage;
      stage_in.rem  = fits ? diff[EB-1:0] : cur[EB-1:0];
      stage_in.root = {in_stage.root[RB-2:0], fits};
      stage_in.rad  = {in_stage.rad[AB-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_stage = stage_ff;

   `RSD_ASSERT_NOW(a_rem_bound, clock, reset,
      !stage_ff.valid || (stage_ff.rem <= EB'({stage_ff.root, 1'b0})))

endmodule

/* hdl/rsd_scale.sv */
`include "radial_spotlight_dimmer_macros.svh"

module rsd_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rsd_pkg::SCALE_STAGES-1:0]    advance,
   input  rsd_pkg::root_stage_type             in_stage,
   output logic [rsd_pkg::SCALE_STAGES-1:0]    busy,
   output rsd_pkg::rgb_type                    rgb_out
);

   localparam int CB = rsd_pkg::CHAN_BITS;
   localparam int PB = rsd_pkg::PROD_BITS;
   localparam int QB = rsd_pkg::QUOT_BITS;
   localparam int XB = rsd_pkg::RECIP_BITS;
   localparam int SH = rsd_pkg::RECIP_SHIFT;

   logic [CB-1:0] factor;
   logic [XB-1:0] qr_red, qr_green, qr_blue;

   logic             p_valid_ff, o_valid_ff, p_zero_ff;
   logic [PB-1:0]    p_red_ff, p_green_ff, p_blue_ff;
   rsd_pkg::rgb_type o_rgb_ff;

   always_comb begin
      factor   = in_stage.far ? '0 : CB'(rsd_pkg::SPOT_RADIUS - in_stage.root);
      qr_red   = XB'(p_red_ff[PB-1:3])   * XB'(rsd_pkg::RECIP_25);
      qr_green = XB'(p_green_ff[PB-1:3]) * XB'(rsd_pkg::RECIP_25);
      qr_blue  = XB'(p_blue_ff[PB-1:3])  * XB'(rsd_pkg::RECIP_25);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (advance[0]) p_valid_ff <= in_stage.valid;
         if (advance[1]) o_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         p_red_ff   <= PB'(in_stage.rgb.red)   * PB'(factor);
         p_green_ff <= PB'(in_stage.rgb.green) * PB'(factor);
         p_blue_ff  <= PB'(in_stage.rgb.blue)  * PB'(factor);
         p_zero_ff  <= factor == '0;
      end
      if (advance[1]) begin
         o_rgb_ff.red   <= qr_red[SH +: CB];
         o_rgb_ff.green <= qr_green[SH +: CB];
         o_rgb_ff.blue  <= qr_blue[SH +: CB];
      end
   end

   assign busy    = {o_valid_ff, p_valid_ff};
   assign rgb_out = o_rgb_ff;

   `RSD_ASSERT_NEXT(a_far_dark, clock, reset, advance[1] && p_valid_ff && p_zero_ff,
      o_valid_ff && (o_rgb_ff == '0))

endmodule

/* hdl/radial_spotlight_dimmer.sv */
// Radial spotlight dimmer: darkens each pixel by its distance from a set center.
// Input channel req_*: one pixel per item with coordinates and red, green, blue.
// Result channel rsp_*: one dimmed pixel per input item, in input order.
// Both channels move an item at a clock edge with valid high and stall low.
// Configuration: csr_write with csr_index selects center_x or center_y and
// csr_data gives the signed 14-bit value; write only while no item is in flight.
// Pipeline of 13 stages: 3 stages form the squared distance, 8 square-root
// cells each settle one root bit, 2 stages scale the channels; it takes one
// item per cycle while the receiver does not stall.
// When the receiver stalls, the result holds and stages behind it keep
// filling any empty slots; req_stall rises only once every stage is full.
// Reset (synchronous) empties the pipeline and sets the center to (0, 0).
`include "radial_spotlight_dimmer_macros.svh"

module radial_spotlight_dimmer #(
   parameter int COORD_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [COORD_BITS-1:0]            req_pos_x,
   input  logic [COORD_BITS-1:0]            req_pos_y,
   input  logic [rsd_pkg::CHAN_BITS-1:0]    req_red_in,
   input  logic [rsd_pkg::CHAN_BITS-1:0]    req_green_in,
   input  logic [rsd_pkg::CHAN_BITS-1:0]    req_blue_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rsd_pkg::CHAN_BITS-1:0]    rsp_red_out,
   output logic [rsd_pkg::CHAN_BITS-1:0]    rsp_green_out,
   output logic [rsd_pkg::CHAN_BITS-1:0]    rsp_blue_out,
   input  logic                             csr_write,
   input  rsd_pkg::csr_index_type           csr_index,
   input  logic [rsd_pkg::CENTER_BITS-1:0]  csr_data
);

   localparam int NS = rsd_pkg::STAGE_COUNT;
   localparam int NF = rsd_pkg::FRONT_STAGES;
   localparam int NC = rsd_pkg::CELL_COUNT;
   localparam int NK = rsd_pkg::SCALE_STAGES;

   logic [rsd_pkg::CENTER_BITS-1:0] center_x_ff, center_y_ff;
   logic [NS-1:0] busy, advance;
   rsd_pkg::rgb_type req_rgb, rsp_rgb;
   rsd_pkg::root_stage_type chain [NC+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            rsd_pkg::CSR_CENTER_X: center_x_ff <= csr_data;
            rsd_pkg::CSR_CENTER_Y: center_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // advance a stage when it is empty or the stage after it moves
   always_comb begin
      advance[NS-1] = !busy[NS-1] || !rsp_stall;
      for (int i = NS - 2; i >= 0; i--) begin
         advance[i] = !busy[i] || advance[i+1];
      end
   end

   assign req_rgb = '{red: req_red_in, green: req_green_in, blue: req_blue_in};

   rsd_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance[NF-1:0]),
      .in_valid  (req_valid),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .rgb       (req_rgb),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .busy      (busy[NF-1:0]),
      .out_stage (chain[0])
   );

   for (genvar g = 0; g < NC; g++) begin : g_cell
      rsd_root_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance[NF+g]),
         .in_stage  (chain[g]),
         .out_stage (chain[g+1])
      );
      assign busy[NF+g] = chain[g+1].valid;
   end

   rsd_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance[NS-1 -: NK]),
      .in_stage (chain[NC]),
      .busy     (busy[NS-1 -: NK]),
      .rgb_out  (rsp_rgb)
   );

   assign req_stall     = !advance[0];
   assign rsp_valid     = busy[NS-1];
   assign rsp_red_out   = rsp_rgb.red;
   assign rsp_green_out = rsp_rgb.green;
   assign rsp_blue_out  = rsp_rgb.blue;

   `RSD_ASSERT_NOW(a_empty_out_takes, clock, reset, rsp_valid || !req_stall)

endmodule

/* tb/radial_spotlight_dimmer_checker.sv */
module radial_spotlight_dimmer_checker #(
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [COORD_BITS-1:0]           req_pos_x,
   input  logic [COORD_BITS-1:0]           req_pos_y,
   input  logic [rsd_pkg::CHAN_BITS-1:0]   req_red_in,
   input  logic [rsd_pkg::CHAN_BITS-1:0]   req_green_in,
   input  logic [rsd_pkg::CHAN_BITS-1:0]   req_blue_in,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [rsd_pkg::CHAN_BITS-1:0]   rsp_red_out,
   input  logic [rsd_pkg::CHAN_BITS-1:0]   rsp_green_out,
   input  logic [rsd_pkg::CHAN_BITS-1:0]   rsp_blue_out,
   input  logic                            csr_write,
   input  rsd_pkg::csr_index_type          csr_index,
   input  logic [rsd_pkg::CENTER_BITS-1:0] csr_data,
   output int                              fail_count,
   output int                              pending_count,
   output int                              pixel_count,
   output int                              dark_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHAN_BITS      = rsd_pkg::CHAN_BITS;
   localparam int CENTER_BITS    = rsd_pkg::CENTER_BITS;
   localparam int FALLOFF_RADIUS = 200;

   logic signed [CENTER_BITS-1:0] center_x = '0;
   logic signed [CENTER_BITS-1:0] center_y = '0;
   rsd_pkg::rgb_type dimmed_q[$];
   int fails = 0;
   int pixels = 0;
   int darks = 0;

   function automatic int spot_distance(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
      longint dx;
      longint dy;
      longint sq;
      int root;
      int trial;
      dx = longint'(px) - longint'(center_x);
      dy = longint'(py) - longint'(center_y);
      sq = dx * dx + dy * dy;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
         trial = root | (1 << b);
         if (longint'(trial) * trial <= sq) root = trial;
      end
      return root;
   endfunction

   function automatic logic [CHAN_BITS-1:0] dim_level(logic [CHAN_BITS-1:0] level, int reach);
      if (reach >= FALLOFF_RADIUS) return '0;
      return CHAN_BITS'((int'(level) * (FALLOFF_RADIUS - reach)) / FALLOFF_RADIUS);
   endfunction

   always @(posedge clock) begin : watch
      rsd_pkg::rgb_type want;
      int reach;
      if (reset) begin
         center_x = '0;
         center_y = '0;
         dimmed_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (dimmed_q.size() == 0) begin
               $error("unexpected result item: red_out %0d green_out %0d blue_out %0d",
                      rsp_red_out, rsp_green_out, rsp_blue_out);
               fails++;
            end else begin
               want = dimmed_q.pop_front();
               if (rsp_red_out !== want.red) begin
                  $error("red_out: expected %0d, got %0d", want.red, rsp_red_out);
                  fails++;
               end
               if (rsp_green_out !== want.green) begin
                  $error("green_out: expected %0d, got %0d", want.green, rsp_green_out);
                  fails++;
               end
               if (rsp_blue_out !== want.blue) begin
                  $error("blue_out: expected %0d, got %0d", want.blue, rsp_blue_out);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            reach = spot_distance(req_pos_x, req_pos_y);
            want.red   = dim_level(req_red_in, reach);
            want.green = dim_level(req_green_in, reach);
            want.blue  = dim_level(req_blue_in, reach);
            dimmed_q.push_back(want);
            pixels++;
            if (reach >= FALLOFF_RADIUS) darks++;
         end
         if (csr_write) begin
            case (csr_index)
               rsd_pkg::CSR_CENTER_X: center_x = csr_data;
               rsd_pkg::CSR_CENTER_Y: center_y = csr_data;
               default: ;
            endcase
         end
      end
      fail_count    <= fails;
      pending_count <= dimmed_q.size();
      pixel_count   <= pixels;
      dark_count    <= darks;
   end

endmodule

/* tb/radial_spotlight_dimmer_tb.sv */
module radial_spotlight_dimmer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHAN_BITS   = rsd_pkg::CHAN_BITS;
   localparam int CENTER_BITS = rsd_pkg::CENTER_BITS;
   localparam int COORD_BITS  = 12;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int QUIET_LIMIT = 2000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [COORD_BITS-1:0]  req_pos_x = '0;
   logic [COORD_BITS-1:0]  req_pos_y = '0;
   logic [CHAN_BITS-1:0]   req_red_in = '0;
   logic [CHAN_BITS-1:0]   req_green_in = '0;
   logic [CHAN_BITS-1:0]   req_blue_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CHAN_BITS-1:0]   rsp_red_out;
   logic [CHAN_BITS-1:0]   rsp_green_out;
   logic [CHAN_BITS-1:0]   rsp_blue_out;
   logic                   csr_write = 1'b0;
   rsd_pkg::csr_index_type csr_index = rsd_pkg::CSR_CENTER_X;
   logic [CENTER_BITS-1:0] csr_data = '0;

   int fail_count;
   int pending_count;
   int pixel_count;
   int dark_count;

   int burst_left = 0;
   int gap_max = 0;
   int stall_mode = 0;
   int stall_run = 0;
   int quiet_cycles = 0;
   int settings = 1;

   radial_spotlight_dimmer #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_red_in(req_red_in),
      .req_green_in(req_green_in),
      .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   radial_spotlight_dimmer_checker #(
      .COORD_BITS(COORD_BITS)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_red_in(req_red_in),
      .req_green_in(req_green_in),
      .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count),
      .pending_count(pending_count),
      .pixel_count(pixel_count),
      .dark_count(dark_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || stall_mode == 0) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run == 0) begin
         if ($urandom_range(0, 3) < stall_mode) begin
            rsp_stall <= 1'b1;
            stall_run <= (stall_mode == 1) ? $urandom_range(0, 5) : $urandom_range(0, 19);
         end else begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(0, 11);
         end
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("radial_spotlight_dimmer_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pixel(int px, int py, int red, int green, int blue);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid    <= 1'b1;
      req_pos_x    <= COORD_BITS'(px);
      req_pos_y    <= COORD_BITS'(py);
      req_red_in   <= CHAN_BITS'(red);
      req_green_in <= CHAN_BITS'(green);
      req_blue_in  <= CHAN_BITS'(blue);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_center(int cx, int cy);
      drain_pipeline();
      csr_write <= 1'b1;
      csr_index <= rsd_pkg::CSR_CENTER_X;
      csr_data  <= CENTER_BITS'(cx);
      @(posedge clock);
      csr_index <= rsd_pkg::CSR_CENTER_Y;
      csr_data  <= CENTER_BITS'(cy);
      @(posedge clock);
      csr_write <= 1'b0;
      burst_left = 0;
      settings++;
   endtask

   function automatic int pick_coord(int center, bit near);
      int v;
      if (!near) return $urandom_range(0, COORD_MAX);
      v = center + int'($urandom_range(0, 520)) - 260;
      return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   task automatic run_phase(int cx, int cy, int count, int gaps, int stalls);
      bit near;
      set_center(cx, cy);
      gap_max = gaps;
      stall_mode <= stalls;
      repeat (count) begin
         near = ($urandom_range(0, 3) != 0);
         send_pixel(pick_coord(cx, near), pick_coord(cy, near), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      gap_max = 2;
      stall_mode <= 1;

      send_pixel(0, 0, 255, 255, 255);
      send_pixel(0, 0, 0, 0, 0);
      send_pixel(1, 1, 255, 128, 1);
      send_pixel(100, 0, 200, 100, 50);
      send_pixel(199, 0, 255, 255, 255);
      send_pixel(200, 0, 255, 255, 255);
      send_pixel(0, 200, 255, 255, 255);
      send_pixel(120, 160, 255, 255, 255);
      send_pixel(119, 160, 255, 254, 253);
      send_pixel(141, 141, 255, 255, 255);
      send_pixel(142, 142, 255, 255, 255);
      send_pixel(COORD_MAX, COORD_MAX, 255, 255, 255);
      send_pixel(COORD_MAX, 0, 170, 85, 255);

      set_center(-100, -50);
      send_pixel(0, 0, 255, 255, 255);
      send_pixel(0, 0, 1, 2, 3);
      send_pixel(60, 70, 255, 255, 255);
      send_pixel(59, 70, 255, 255, 255);
      send_pixel(100, 100, 255, 255, 255);

      set_center(8191, 8191);
      send_pixel(COORD_MAX, COORD_MAX, 255, 255, 255);
      send_pixel(0, 0, 255, 255, 255);

      set_center(-8192, -8192);
      send_pixel(0, 0, 255, 255, 255);
      send_pixel(COORD_MAX, COORD_MAX, 255, 255, 255);

      run_phase(2048, 2048, 120, 16, 2);
      run_phase(COORD_MAX, COORD_MAX, 100, 0, 0);
      run_phase(-8192, 8191, 30, 3, 1);
      run_phase(-150, 4200, 100, 3, 1);
      run_phase(int'($urandom_range(0, 4400)) - 300, int'($urandom_range(0, 4400)) - 300,
                120, 8, 2);
      run_phase(1000, 3000, 100, 0, 2);
      run_phase(0, 0, 40, 16, 0);

      drain_pipeline();
      repeat (20) @(posedge clock);

      $display("Checked %0d pixels over %0d center settings, %0d at or past radius 200.",
               pixel_count, settings, dark_count);
      $display("Sender bursts and receiver stalls were mixed with unthrottled phases.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("radial_spotlight_dimmer_tb passed");
      end else begin
         $display("radial_spotlight_dimmer_tb failed");
      end
      $finish;
   end

endmodule
